// File: rtl/prtd_pkg.sv
package prtd_pkg;

  localparam int RES_W   = 22;
  localparam int TEMP_W  = 19;
  localparam int STAT_W  = 2;
  localparam int R_W     = 28;   // scaled resistance, Q12.16, below 4096 ohms
  localparam int X_W     = 45;   // resistance * 100 * 2^16
  localparam int CMP_W   = 50;   // nominal << 28
  localparam int DIV_W   = 64;   // |num| << 16
  localparam int Q_W     = 19;   // quotient bits kept
  localparam int Q_DEPTH = 4;

  localparam logic signed [22:0] C4 = -23'sd2275659;
  localparam logic signed [35:0] C3 = 36'sd4444445902;
  localparam logic signed [47:0] C2 = -48'sd72618344968;
  localparam logic signed [44:0] C1 = 45'sd42434612;
  localparam logic signed [22:0] D4 = -23'sd1495456;
  localparam logic signed [35:0] D3 = 36'sd1856305481;
  localparam logic signed [47:0] D2 = -48'sd27951784601;
  localparam logic signed [45:0] ONE_Q24 = 46'sd16777216;

  localparam logic signed [19:0] OFFSET_Q8 = 20'sd62769;
  localparam logic signed [19:0] T_MIN_OK  = -20'sd51200;
  localparam logic signed [19:0] T_MAX     = 20'sd262143;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_LOW    = 2'd2;

  typedef enum logic [1:0] {
    RK_EVAL   = 2'd0,
    RK_NOTPOS = 2'd1,
    RK_SAT    = 2'd2,
    RK_LOW    = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic [R_W-1:0] r;
    res_kind_t      kind;
  } q_entry_t;

endpackage

// File: rtl/prtd_in_if.sv
interface prtd_in_if;
  logic                        valid;
  logic                        ready;
  logic [prtd_pkg::RES_W-1:0]  resistance;

  modport source (output valid, output resistance, input ready);
  modport sink   (input valid, input resistance, output ready);
endinterface

// File: rtl/prtd_out_if.sv
interface prtd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [prtd_pkg::TEMP_W-1:0] temperature;
  logic [prtd_pkg::STAT_W-1:0]        status;

  modport source (output valid, output temperature, output status, input ready);
  modport sink   (input valid, input temperature, input status, output ready);
endinterface

// File: rtl/prtd_front.sv
module prtd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [prtd_pkg::RES_W-1:0] in_resistance,
  output logic                       in_ready,
  input  logic [prtd_pkg::RES_W-1:0] nom,
  input  logic                       q_full,
  output logic                       q_push,
  output prtd_pkg::q_entry_t         q_data
);

  localparam int NST = prtd_pkg::R_W;

  logic [NST:0]                 v_r;
  logic [prtd_pkg::X_W-1:0]     rem_r  [0:NST];
  logic [prtd_pkg::R_W-1:0]     quo_r  [0:NST];
  prtd_pkg::res_kind_t          kind_r [0:NST];

  logic                         adv;
  logic [prtd_pkg::X_W-1:0]     x;
  logic [prtd_pkg::CMP_W-1:0]   lim;
  prtd_pkg::res_kind_t          kind_nxt;

  assign adv      = !v_r[NST] || !q_full;
  assign in_ready = adv;
  assign q_push   = v_r[NST] && !q_full;
  assign q_data   = '{r: quo_r[NST], kind: kind_r[NST]};

  // dividend resistance * 100 * 2^16, quotient must stay below 2^28
  assign x   = (prtd_pkg::X_W'(in_resistance) * prtd_pkg::X_W'(100)) << 16;
  assign lim = {nom, {prtd_pkg::R_W{1'b0}}};

  always_comb begin
    if (in_resistance == '0) begin
      kind_nxt = prtd_pkg::RK_NOTPOS;
    end else if (prtd_pkg::CMP_W'(x) >= lim) begin
      kind_nxt = prtd_pkg::RK_SAT;
    end else begin
      kind_nxt = prtd_pkg::RK_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= x;
      quo_r[0]  <= '0;
      kind_r[0] <= kind_nxt;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < NST; k++) begin : g_div
    localparam int BIT = NST - 1 - k;
    logic [prtd_pkg::CMP_W-1:0] dsh;
    logic                       ge;

    assign dsh = prtd_pkg::CMP_W'(nom) << BIT;
    assign ge  = prtd_pkg::CMP_W'(rem_r[k]) >= dsh;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= ge ? rem_r[k] - prtd_pkg::X_W'(dsh) : rem_r[k];
        quo_r[k+1]  <= quo_r[k] | (prtd_pkg::R_W'(ge) << BIT);
        kind_r[k+1] <= kind_r[k];
      end
    end
  end

endmodule

// File: rtl/prtd_queue.sv
module prtd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  prtd_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output prtd_pkg::q_entry_t pop_data,
  output logic               empty
);

  localparam int PW = $clog2(prtd_pkg::Q_DEPTH);

  prtd_pkg::q_entry_t mem [0:prtd_pkg::Q_DEPTH-1];
  logic [PW-1:0]      wp_r, rp_r;
  logic [PW:0]        cnt_r;

  assign full     = cnt_r == (PW+1)'(prtd_pkg::Q_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> cnt_r == (PW+1)'(prtd_pkg::Q_DEPTH) || $past(!push))
    else $error("queue overrun");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(prtd_pkg::Q_DEPTH))
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> wp_r == rp_r)
    else $error("queue pointers disagree with count");

endmodule

// File: rtl/prtd_back.sv
module prtd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  prtd_pkg::q_entry_t                 q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [prtd_pkg::TEMP_W-1:0] out_temperature,
  output logic [prtd_pkg::STAT_W-1:0]        out_status
);

  localparam int NQ = prtd_pkg::Q_W;
  localparam int NB = 9 + NQ;

  logic            adv;
  logic [NB-1:0]   sv_r;
  logic            out_valid_r;

  // polynomial lanes
  logic [prtd_pkg::R_W-1:0] r1_r, r2_r, r3_r, r4_r, r5_r, r6_r;
  prtd_pkg::res_kind_t      k1_r, k2_r, k3_r, k4_r, k5_r, k6_r, k7_r, k8_r;
  logic signed [51:0] p1n_r, p1d_r;
  logic signed [35:0] an2_r, ad2_r;
  logic signed [46:0] pnh3_r, pdh3_r;
  logic signed [47:0] pnl3_r, pdl3_r;
  logic signed [47:0] bn4_r, bd4_r;
  logic signed [60:0] pn5_r, pd5_r;
  logic signed [44:0] cn6_r;
  logic signed [45:0] dd6_r, dd7_r, dd8_r;
  logic signed [47:0] pnh7_r, pnl7_r;
  logic signed [47:0] num8_r;

  // divider lanes
  logic [prtd_pkg::DIV_W-1:0] rem_r [0:NQ];
  logic [45:0]                dsr_r [0:NQ];
  logic [NQ-1:0]              quo_r [0:NQ];
  prtd_pkg::res_kind_t        dk_r  [0:NQ];

  logic signed [prtd_pkg::TEMP_W-1:0] temp_r, temp_nxt;
  logic [prtd_pkg::STAT_W-1:0]        stat_r, stat_nxt;

  logic signed [28:0] rs_in, rs2, rs4, rs6;
  logic signed [17:0] anh, adh;
  logic signed [18:0] anl, adl;
  logic signed [63:0] prn4, prd4, prn8;
  logic signed [31:0] bsn, bsd;
  logic signed [36:0] c8;
  logic signed [18:0] c8h, c8l;
  logic [46:0]        nmag;
  logic [45:0]        dmag;
  logic               ovf;
  prtd_pkg::res_kind_t k9_nxt;
  logic signed [19:0] t20;

  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = out_valid_r;
  assign out_temperature = temp_r;
  assign out_status      = stat_r;

  assign rs_in = signed'({1'b0, q_data.r});
  assign rs2   = signed'({1'b0, r2_r});
  assign rs4   = signed'({1'b0, r4_r});
  assign rs6   = signed'({1'b0, r6_r});

  assign anh = an2_r[35:18];
  assign anl = signed'({1'b0, an2_r[17:0]});
  assign adh = ad2_r[35:18];
  assign adl = signed'({1'b0, ad2_r[17:0]});
  assign prn4 = (64'(pnh3_r) <<< 18) + 64'(pnl3_r);
  assign prd4 = (64'(pdh3_r) <<< 18) + 64'(pdl3_r);
  assign bsn = 32'(bn4_r >>> 16);
  assign bsd = 32'(bd4_r >>> 16);
  assign c8  = 37'(cn6_r >>> 8);
  assign c8h = c8[36:18];
  assign c8l = signed'({1'b0, c8[17:0]});
  assign prn8 = (64'(pnh7_r) <<< 18) + 64'(pnl7_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sv_r        <= {sv_r[NB-2:0], !q_empty};
      out_valid_r <= sv_r[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_r <= q_data.r;    k1_r <= q_data.kind;
      p1n_r <= prtd_pkg::C4 * rs_in;
      p1d_r <= prtd_pkg::D4 * rs_in;

      r2_r <= r1_r;        k2_r <= k1_r;
      an2_r <= prtd_pkg::C3 + 36'(p1n_r >>> 16);
      ad2_r <= prtd_pkg::D3 + 36'(p1d_r >>> 16);

      r3_r <= r2_r;        k3_r <= k2_r;
      pnh3_r <= anh * rs2;
      pnl3_r <= anl * rs2;
      pdh3_r <= adh * rs2;
      pdl3_r <= adl * rs2;

      r4_r <= r3_r;        k4_r <= k3_r;
      bn4_r <= prtd_pkg::C2 + 48'(prn4 >>> 16);
      bd4_r <= prtd_pkg::D2 + 48'(prd4 >>> 16);

      r5_r <= r4_r;        k5_r <= k4_r;
      pn5_r <= bsn * rs4;
      pd5_r <= bsd * rs4;

      r6_r <= r5_r;        k6_r <= k5_r;
      cn6_r <= prtd_pkg::C1 + 45'(pn5_r >>> 16);
      dd6_r <= prtd_pkg::ONE_Q24 + 46'(pd5_r >>> 16);

      k7_r <= k6_r;
      pnh7_r <= c8h * rs6;
      pnl7_r <= c8l * rs6;
      dd7_r  <= dd6_r;

      k8_r   <= k7_r;
      num8_r <= 48'(prn8 >>> 16);
      dd8_r  <= dd7_r;
    end
  end

  // sign-magnitude prep for the quotient
  assign nmag = num8_r[47] ? 47'(-num8_r) : 47'(num8_r);
  assign dmag = dd8_r[45]  ? 46'(-dd8_r)  : 46'(dd8_r);
  assign ovf  = 64'(nmag) >= (64'(dmag) << 3);

  always_comb begin
    k9_nxt = k8_r;
    if (k8_r == prtd_pkg::RK_EVAL) begin
      if (dd8_r == '0) begin
        k9_nxt = num8_r[47] ? prtd_pkg::RK_LOW : prtd_pkg::RK_SAT;
      end else if (num8_r == '0 || (num8_r[47] ^ dd8_r[45])) begin
        k9_nxt = prtd_pkg::RK_LOW;
      end else if (ovf) begin
        k9_nxt = prtd_pkg::RK_SAT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= 64'(nmag) << 16;
      dsr_r[0] <= dmag;
      quo_r[0] <= '0;
      dk_r[0]  <= k9_nxt;
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_div
    localparam int BIT = NQ - 1 - j;
    logic [prtd_pkg::DIV_W-1:0] dsh;
    logic                       ge;

    assign dsh = 64'(dsr_r[j]) << BIT;
    assign ge  = rem_r[j] >= dsh;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1] <= ge ? rem_r[j] - dsh : rem_r[j];
        dsr_r[j+1] <= dsr_r[j];
        quo_r[j+1] <= quo_r[j] | (NQ'(ge) << BIT);
        dk_r[j+1]  <= dk_r[j];
      end
    end
  end

  assign t20 = signed'({1'b0, quo_r[NQ]}) - prtd_pkg::OFFSET_Q8;

  always_comb begin
    temp_nxt = '0;
    stat_nxt = prtd_pkg::ST_OK;
    case (dk_r[NQ])
      prtd_pkg::RK_NOTPOS: stat_nxt = prtd_pkg::ST_NOTPOS;
      prtd_pkg::RK_SAT:    temp_nxt = 19'(prtd_pkg::T_MAX);
      prtd_pkg::RK_LOW:    stat_nxt = prtd_pkg::ST_LOW;
      prtd_pkg::RK_EVAL: begin
        if (t20 < prtd_pkg::T_MIN_OK) begin
          stat_nxt = prtd_pkg::ST_LOW;
        end else if (t20 > prtd_pkg::T_MAX) begin
          temp_nxt = 19'(prtd_pkg::T_MAX);
        end else begin
          temp_nxt = t20[18:0];
        end
      end
      default: stat_nxt = prtd_pkg::ST_LOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && sv_r[NB-1]) begin
      temp_r <= temp_nxt;
      stat_r <= stat_nxt;
    end
  end

endmodule

// File: rtl/platinum_rtd_resistance_to_temp_core.sv
// platinum rtd resistance to temperature converter
// in_ch carries one measured resistance (ohms * 2^RES_FRAC_BITS) per transfer;
// out_ch returns one temperature (degC * 256, signed) and a status code per
// reading, in the order the readings came in
// the apb port holds the sensor's resistance at 0 degC at address 0; a write
// of zero is dropped, reads return the current value, pready is always high
// throughput is one reading per cycle while the receiver keeps ready high,
// set by the two pipelined restoring dividers (28 stages for the pt100
// scaling, 19 for the final quotient), each resolving one quotient bit
// per stage
// the front pipeline scales and classifies, a four-entry queue decouples it
// from the back pipeline that evaluates the rational polynomial
// when the receiver stalls, the back pipeline freezes behind the output
// register, the queue fills, and in_ch.ready drops only once it is full
// reset clears all pipeline valids and the queue and loads the nominal
// resistance with 100 ohms; no clearing pass is needed
module platinum_rtd_resistance_to_temp_core #(
  parameter int RES_FRAC_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  prtd_in_if.sink     in_ch,
  prtd_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // 100 ohms at the configured fraction, wrapped into the register width
  localparam logic [prtd_pkg::RES_W-1:0] NOM_RESET =
    prtd_pkg::RES_W'((100 * (1 << RES_FRAC_BITS)) % (1 << prtd_pkg::RES_W));

  logic [prtd_pkg::RES_W-1:0] nom_r;
  logic                       cfg_wr;

  logic               q_push, q_full, q_pop, q_empty;
  prtd_pkg::q_entry_t q_wdata, q_rdata;

  // apb register, write completes on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(nom_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_r <= NOM_RESET;
    end else if (cfg_wr && pwdata[prtd_pkg::RES_W-1:0] != '0) begin
      nom_r <= pwdata[prtd_pkg::RES_W-1:0];
    end
  end

  // front: zero check, range check and resistance * 100 / nominal
  prtd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_resistance (in_ch.resistance),
    .in_ready      (in_ch.ready),
    .nom           (nom_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  prtd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: horner numerator and denominator, quotient, offset and clamp
  prtd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_temperature (out_ch.temperature),
    .out_status      (out_ch.status)
  );

  a_zero_write_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pwdata[prtd_pkg::RES_W-1:0] == '0 |=> $stable(nom_r))
    else $error("zero nominal write changed the register");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");
  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == prtd_pkg::ST_OK
      |-> out_ch.temperature >= 19'(prtd_pkg::T_MIN_OK))
    else $error("ok status with temperature below -200 degC");
  a_err_zero_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != prtd_pkg::ST_OK |-> out_ch.temperature == '0)
    else $error("error status with nonzero temperature");

endmodule

// File: verif/platinum_rtd_resistance_to_temp_core_tb.sv
module platinum_rtd_resistance_to_temp_core_tb;

  // register map: nominal resistance at 0 degC sits at index 0
  localparam logic [2:0] ADDR_NOMINAL = 3'd0;
  // an address with bit 2 set, outside the register list, writes there must be dropped
  localparam logic [2:0] ADDR_SPARE   = 3'd4;
  localparam int RES_MAX      = 4194303;
  localparam int PT100_NOM    = 102400;
  localparam int ITEMS_PHASE  = 270;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [prtd_pkg::TEMP_W-1:0] temperature;
    logic [prtd_pkg::STAT_W-1:0]        status;
  } reading_t;

  // scoreboard: converts each accepted resistance to its expected reading
  class rtd_scoreboard;
    reading_t   pending_q[$];
    logic [21:0] nominal;
    int         mismatches;

    function void set_nominal(logic [31:0] value);
      if (value[21:0] != 0) nominal = value[21:0];
    endfunction

    function reading_t convert(logic [21:0] res);
      reading_t rd;
      longint r, a, b, c, num, den, q, t;
      rd.temperature = '0;
      rd.status      = prtd_pkg::ST_OK;
      if (res == 0) begin
        rd.status = prtd_pkg::ST_NOTPOS;
        return rd;
      end
      // pt100-equivalent resistance, Q12.16
      r = (longint'(res) * 100 * 65536) / longint'(nominal);
      if (r >= (longint'(4096) << 16)) begin
        rd.temperature = prtd_pkg::T_MAX[prtd_pkg::TEMP_W-1:0];
        return rd;
      end
      // numerator quartic, horner form; >>> on signed is a floor shift
      a = longint'(prtd_pkg::C3) + ((longint'(prtd_pkg::C4) * r) >>> 16);
      b = longint'(prtd_pkg::C2) + ((a * r) >>> 16);
      c = longint'(prtd_pkg::C1) + (((b >>> 16) * r) >>> 16);
      num = ((c >>> 8) * r) >>> 16;
      // denominator cubic
      a = longint'(prtd_pkg::D3) + ((longint'(prtd_pkg::D4) * r) >>> 16);
      b = longint'(prtd_pkg::D2) + ((a * r) >>> 16);
      den = longint'(prtd_pkg::ONE_Q24) + (((b >>> 16) * r) >>> 16);
      if (den == 0) begin
        if (num >= 0) rd.temperature = prtd_pkg::T_MAX[prtd_pkg::TEMP_W-1:0];
        else rd.status = prtd_pkg::ST_LOW;
        return rd;
      end
      q = (num * 65536) / den;
      t = q - longint'(prtd_pkg::OFFSET_Q8);
      if (t < longint'(prtd_pkg::T_MIN_OK)) begin
        rd.status = prtd_pkg::ST_LOW;
        return rd;
      end
      if (t > longint'(prtd_pkg::T_MAX)) t = longint'(prtd_pkg::T_MAX);
      rd.temperature = t[prtd_pkg::TEMP_W-1:0];
      return rd;
    endfunction

    function void note_reading(logic [21:0] res);
      pending_q.push_back(convert(res));
    endfunction

    function void check_reading(logic signed [prtd_pkg::TEMP_W-1:0] temperature,
                                logic [prtd_pkg::STAT_W-1:0] status);
      reading_t exp_rd;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading temp=%0d status=%0d", temperature, status);
        return;
      end
      exp_rd = pending_q.pop_front();
      if (exp_rd.temperature !== temperature || exp_rd.status !== status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reading mismatch: expected temp=%0d status=%0d, got temp=%0d status=%0d",
                   exp_rd.temperature, exp_rd.status, temperature, status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  prtd_in_if  in_ch ();
  prtd_out_if out_ch ();

  platinum_rtd_resistance_to_temp_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  rtd_scoreboard sb;
  bit quiet;        // no idling on either side in the closing phase
  int idle_cycles;  // cycles since the last transfer on either channel
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitors sample at the rising edge, before any nonblocking update lands
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_reading(in_ch.resistance);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_reading(out_ch.temperature, out_ch.status);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: ready drops at random, in bursts of random length
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_ch.ready = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // apb write: setup cycle then access cycle, register lands at the access edge
  task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (addr == ADDR_NOMINAL) sb.set_nominal(value);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_reading(logic [21:0] res);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.resistance = res;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // wait for every expected reading before touching the register
  task automatic drain();
    @(negedge clk);
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // random reading: mostly the sensor's working range, the rest anything or near zero
  function automatic logic [21:0] random_reading();
    longint v;
    case ($urandom_range(0, 9))
      0, 1:    return 22'($urandom_range(0, RES_MAX));
      2:       return 22'($urandom_range(0, 64));
      default: begin
        // 0.15 to 4.5 times the nominal, covers below -200 to the top of range
        v = (longint'(sb.nominal) * $urandom_range(150, 4500)) / 1000;
        v = v + $urandom_range(0, 63) - 32;
        if (v < 0) v = 0;
        if (v > RES_MAX) v = RES_MAX;
        return v[21:0];
      end
    endcase
  endfunction

  initial begin
    int nominals[6];
    logic [21:0] directed[$];
    sb = new();
    sb.nominal = 22'(PT100_NOM);
    sb.mismatches = 0;
    quiet = 1'b0;
    idle_cycles = 0;
    stall_left = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.resistance = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed readings at the reset nominal (pt100)
    // zero, tiny, max, 0 degC, near the -200 degC edge, hot end, large values
    directed = '{22'd0, 22'd1, 22'd4194303, 22'd102400, 22'd18965, 22'd18400,
                 22'd19500, 22'd400000, 22'd399000, 22'd410000, 22'd4194302,
                 22'd1048575, 22'd2097152, 22'd1048576, 22'd512,
                 22'd138506, 22'd80306, 22'd247092, 22'd419424, 22'd419430};
    foreach (directed[i]) send_reading(directed[i]);

    // phases: reset value, extremes, pt1000, small sensor, back to pt100
    nominals = '{PT100_NOM, 1, RES_MAX, 1024000, 51200, PT100_NOM};
    foreach (nominals[p]) begin
      drain();
      if (p == 1) cfg_write(ADDR_NOMINAL, 32'd0);  // zero write is dropped
      if (p == 2) cfg_write(ADDR_SPARE, 32'd777);  // outside the register list
      if (p > 0) cfg_write(ADDR_NOMINAL, nominals[p]);
      if (p == 4) cfg_write(ADDR_NOMINAL, 32'd0);
      quiet = (p == 5);
      repeat (ITEMS_PHASE) send_reading(random_reading());
    end

    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
